// File: sv/lcfa_pkg.sv
// ----------------------------------------------------------------------------
// Linked-cell allocator package
// Shared widths, codes, transaction structs and the control store of the
// microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfa_pkg;

   localparam int CELLS   = 64;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int LINK_W  = $clog2(CELLS + 1);
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   localparam logic [LINK_W-1:0] NIL_LINK   = LINK_W'(CELLS);
   localparam logic [LINK_W-1:0] CELL_COUNT = LINK_W'(CELLS);

   typedef enum logic [2:0] {
      FN_ALLOC   = 3'd0,
      FN_WRITE   = 3'd1,
      FN_READ    = 3'd2,
      FN_FREE    = 3'd3,
      FN_COUNT   = 3'd4,
      FN_IS_FREE = 3'd5
   } lcfa_func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_NOT_FOUND = 2'd2
   } lcfa_status_type;

   typedef struct packed {
      logic [2:0]                func;
      logic [KEY_W-1:0]          key;
      logic                      chain_end;
      logic [5:0]                address;
      logic signed [VALUE_W-1:0] value;
   } lcfa_req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [5:0]                cell_address;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        free_count;
      logic [COUNT_W-1:0]        used_count;
      logic                      is_free;
   } lcfa_rsp_type;

   // Datapath operation carried by each control word.
   typedef enum logic [2:0] {
      DP_FETCH,
      DP_ALLOC_CHK,
      DP_ALLOC_POP,
      DP_WALK_START,
      DP_WALK,
      DP_EMIT,
      DP_FREE_START,
      DP_FREE_WALK
   } lcfa_dp_op_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_DISPATCH,
      C_HEAD_NIL,
      C_WALK_MORE,
      C_FWALK_MORE,
      C_OUT_BUSY
   } lcfa_cond_type;

   typedef enum logic [2:0] {
      U_FETCH,
      U_A_CHK,
      U_A_POP,
      U_K_START,
      U_K_WALK,
      U_EMIT,
      U_F_START,
      U_F_WALK
   } lcfa_upc_type;

   typedef struct packed {
      lcfa_dp_op_type op;
      lcfa_cond_type  cond;
      lcfa_upc_type   tgt_t;
      lcfa_upc_type   tgt_f;
   } lcfa_uword_type;

   // Status from the datapath that the sequencer branches on.
   typedef struct packed {
      logic       accept;
      logic [2:0] func;
      logic       head_nil;
      logic       walk_more;
      logic       fwalk_more;
      logic       out_busy;
   } lcfa_flag_type;

   typedef struct packed {
      logic                 key_we;
      logic                 val_we;
      logic                 link_we;
      logic [ADDR_W-1:0]    addr;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
      logic [LINK_W-1:0]    link;
   } lcfa_wr_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [LINK_W-1:0]  link;
   } lcfa_rdata_type;

   // Control store: one word per step. The branch goes to tgt_t when the
   // condition holds and to tgt_f otherwise.
   function automatic lcfa_uword_type lcfa_ucode(input lcfa_upc_type pc);
      lcfa_uword_type w;
      case (pc)
         U_FETCH:   w = '{DP_FETCH,      C_DISPATCH,   U_FETCH,   U_FETCH};
         U_A_CHK:   w = '{DP_ALLOC_CHK,  C_HEAD_NIL,   U_EMIT,    U_A_POP};
         U_A_POP:   w = '{DP_ALLOC_POP,  C_ALWAYS,     U_EMIT,    U_EMIT};
         U_K_START: w = '{DP_WALK_START, C_ALWAYS,     U_K_WALK,  U_K_WALK};
         U_K_WALK:  w = '{DP_WALK,       C_WALK_MORE,  U_K_WALK,  U_EMIT};
         U_EMIT:    w = '{DP_EMIT,       C_OUT_BUSY,   U_EMIT,    U_FETCH};
         U_F_START: w = '{DP_FREE_START, C_ALWAYS,     U_F_WALK,  U_F_WALK};
         U_F_WALK:  w = '{DP_FREE_WALK,  C_FWALK_MORE, U_F_WALK,  U_EMIT};
         default:   w = '{DP_FETCH,      C_ALWAYS,     U_FETCH,   U_FETCH};
      endcase
      return w;
   endfunction

   // First step of the routine for each function code.
   function automatic lcfa_upc_type lcfa_entry(input logic [2:0] func);
      lcfa_upc_type e;
      if (func inside {FN_WRITE, FN_READ, FN_COUNT, FN_IS_FREE}) begin
         e = U_K_START;
      end else if (func == FN_ALLOC) begin
         e = U_A_CHK;
      end else if (func == FN_FREE) begin
         e = U_F_START;
      end else begin
         e = U_EMIT;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

// File: sv/lcfa_store.sv
// ----------------------------------------------------------------------------
// Linked-cell allocator cell store
// Key, value and link memories with one shared registered read port and
// per-entry valid bits that stand in for the reset contents.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfa_store
   import lcfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  lcfa_wr_type         wr,
   output lcfa_rdata_type      rdata
);

   logic [KEY_W-1:0]   key_mem_ff  [CELLS];
   logic [VALUE_W-1:0] val_mem_ff  [CELLS];
   logic [LINK_W-1:0]  link_mem_ff [CELLS];

   logic [CELLS-1:0]   key_vld_ff;
   logic [CELLS-1:0]   val_vld_ff;
   logic [CELLS-1:0]   link_vld_ff;

   logic [KEY_W-1:0]   key_rd_ff;
   logic [VALUE_W-1:0] val_rd_ff;
   logic [LINK_W-1:0]  link_rd_ff;
   logic               key_hit_ff;
   logic               val_hit_ff;
   logic               link_hit_ff;
   logic [ADDR_W-1:0]  raddr_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem_ff[wr.addr] <= wr.key;
      end
      if (wr.val_we) begin
         val_mem_ff[wr.addr] <= wr.value;
      end
      if (wr.link_we) begin
         link_mem_ff[wr.addr] <= wr.link;
      end
      key_rd_ff   <= key_mem_ff[rd_addr];
      val_rd_ff   <= val_mem_ff[rd_addr];
      link_rd_ff  <= link_mem_ff[rd_addr];
      key_hit_ff  <= key_vld_ff[rd_addr];
      val_hit_ff  <= val_vld_ff[rd_addr];
      link_hit_ff <= link_vld_ff[rd_addr];
      raddr_ff    <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff  <= '0;
         val_vld_ff  <= '0;
         link_vld_ff <= '0;
      end else begin
         if (wr.key_we) begin
            key_vld_ff[wr.addr] <= 1'b1;
         end
         if (wr.val_we) begin
            val_vld_ff[wr.addr] <= 1'b1;
         end
         if (wr.link_we) begin
            link_vld_ff[wr.addr] <= 1'b1;
         end
      end
   end

   // An entry never written reads as its reset contents: zero key and value,
   // and a link to the next cell (the last cell's successor is nil).
   always_comb begin
      rdata.key   = key_hit_ff ? key_rd_ff : '0;
      rdata.value = val_hit_ff ? val_rd_ff : '0;
      rdata.link  = link_hit_ff ? link_rd_ff
                                : LINK_W'(raddr_ff) + LINK_W'(1);
   end

endmodule

`default_nettype wire

// File: sv/lcfa_seq.sv
// ----------------------------------------------------------------------------
// Linked-cell allocator microsequencer
// Step counter over the control store, with dispatch on the function code
// and two-way conditional branches on datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfa_seq
   import lcfa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lcfa_flag_type  flags,
   output lcfa_dp_op_type ctl
);

   lcfa_upc_type   pc_ff;
   lcfa_upc_type   pc_in;
   lcfa_uword_type uw;

   assign uw = lcfa_ucode(pc_ff);

   always_comb begin
      case (uw.cond)
         C_ALWAYS:     pc_in = uw.tgt_t;
         C_DISPATCH:   pc_in = flags.accept ? lcfa_entry(flags.func) : uw.tgt_f;
         C_HEAD_NIL:   pc_in = flags.head_nil ? uw.tgt_t : uw.tgt_f;
         C_WALK_MORE:  pc_in = flags.walk_more ? uw.tgt_t : uw.tgt_f;
         C_FWALK_MORE: pc_in = flags.fwalk_more ? uw.tgt_t : uw.tgt_f;
         C_OUT_BUSY:   pc_in = flags.out_busy ? uw.tgt_t : uw.tgt_f;
         default:      pc_in = U_FETCH;
      endcase
   end

   always_comb begin
      ctl = uw.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= U_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/lcfa_dpath.sv
// ----------------------------------------------------------------------------
// Linked-cell allocator datapath
// Request and result registers, free-list head, walk pointer and step
// counter, driven by the operation of the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfa_dpath
   import lcfa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lcfa_dp_op_type ctl,
   input  logic           req_valid,
   output logic           req_ready,
   input  lcfa_req_type   req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output lcfa_rsp_type   rsp_data,
   input  lcfa_rdata_type rdata,
   output logic [ADDR_W-1:0] rd_addr,
   output lcfa_wr_type    wr,
   output lcfa_flag_type  flags
);

   lcfa_req_type       req_ff,    req_in;
   logic [LINK_W-1:0]  head_ff,   head_in;
   logic [LINK_W-1:0]  z_ff,      z_in;
   logic [LINK_W-1:0]  steps_ff,  steps_in;
   logic               found_ff,  found_in;
   logic               fr_ff,     fr_in;
   logic [VALUE_W-1:0] rd_ff,     rd_in;
   logic [ADDR_W-1:0]  cell_ff,   cell_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lcfa_rsp_type       rsp_ff,    rsp_in;

   logic               live;
   logic               hit;
   logic               stop;
   logic               link_nil;
   logic               fmore;
   logic               keyed;
   logic [LINK_W-1:0]  start;

   assign live     = (steps_ff != CELL_COUNT) && (z_ff < CELL_COUNT);
   assign hit      = rdata.key == req_ff.key;
   assign stop     = ((req_ff.func == FN_READ) && hit)
                  || ((req_ff.func == FN_IS_FREE) && (z_ff == LINK_W'(req_ff.address)));
   assign link_nil = !(rdata.link < CELL_COUNT);
   assign fmore    = (steps_ff != CELL_COUNT) && !link_nil;
   assign keyed    = (req_ff.func == FN_WRITE) || (req_ff.func == FN_READ);
   assign start    = ((req_ff.func == FN_COUNT) || (req_ff.func == FN_IS_FREE))
                     ? head_ff : LINK_W'(req_ff.address);

   // No transaction is taken while reset is held.
   assign req_ready = (ctl == DP_FETCH) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      flags.accept     = req_valid && req_ready;
      flags.func       = req_data.func;
      flags.head_nil   = !(head_ff < CELL_COUNT);
      flags.walk_more  = live && !stop;
      flags.fwalk_more = fmore;
      flags.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      req_in       = req_ff;
      head_in      = head_ff;
      z_in         = z_ff;
      steps_in     = steps_ff;
      found_in     = found_ff;
      fr_in        = fr_ff;
      rd_in        = rd_ff;
      cell_in      = cell_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = z_ff[ADDR_W-1:0];
      wr           = '0;
      wr.addr      = z_ff[ADDR_W-1:0];
      wr.key       = req_ff.key;
      wr.value     = req_ff.value;
      wr.link      = NIL_LINK;

      case (ctl)
         DP_FETCH: begin
            if (req_valid) begin
               req_in    = req_data;
               found_in  = 1'b0;
               fr_in     = 1'b0;
               rd_in     = '0;
               cell_in   = '0;
               status_in = ST_OK;
               steps_in  = '0;
            end
         end
         DP_ALLOC_CHK: begin
            rd_addr = head_ff[ADDR_W-1:0];
            if (!(head_ff < CELL_COUNT)) begin
               status_in = ST_NO_FREE;
            end
         end
         DP_ALLOC_POP: begin
            cell_in    = head_ff[ADDR_W-1:0];
            wr.addr    = head_ff[ADDR_W-1:0];
            wr.key_we  = 1'b1;
            wr.link_we = req_ff.chain_end;
            head_in    = link_nil ? NIL_LINK : rdata.link;
         end
         DP_WALK_START: begin
            z_in     = start;
            steps_in = '0;
            rd_addr  = start[ADDR_W-1:0];
         end
         DP_WALK: begin
            if (live) begin
               if (hit && (req_ff.func == FN_WRITE)) begin
                  wr.val_we = 1'b1;
                  found_in  = 1'b1;
               end
               if (hit && (req_ff.func == FN_READ)) begin
                  rd_in    = rdata.value;
                  found_in = 1'b1;
               end
               if ((req_ff.func == FN_IS_FREE) && (z_ff == LINK_W'(req_ff.address))) begin
                  fr_in = 1'b1;
               end
               if (!stop) begin
                  z_in     = rdata.link;
                  steps_in = steps_ff + LINK_W'(1);
                  rd_addr  = rdata.link[ADDR_W-1:0];
               end
            end
         end
         DP_FREE_START: begin
            z_in     = LINK_W'(req_ff.address);
            steps_in = '0;
            rd_addr  = req_ff.address;
         end
         DP_FREE_WALK: begin
            if (fmore) begin
               z_in     = rdata.link;
               steps_in = steps_ff + LINK_W'(1);
               rd_addr  = rdata.link[ADDR_W-1:0];
            end else if (link_nil) begin
               // The chain's tail is found: splice it in front of the free list.
               wr.link_we = 1'b1;
               wr.link    = head_ff;
               head_in    = LINK_W'(req_ff.address);
            end
         end
         DP_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = keyed ? (found_ff ? ST_OK : ST_NOT_FOUND) : status_ff;
               rsp_in.cell_address = cell_ff;
               rsp_in.read_value   = rd_ff;
               rsp_in.free_count   = (req_ff.func == FN_COUNT) ? COUNT_W'(steps_ff) : '0;
               rsp_in.used_count   = (req_ff.func == FN_COUNT)
                                     ? COUNT_W'(CELL_COUNT - steps_ff) : '0;
               rsp_in.is_free      = fr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      z_ff      <= z_in;
      steps_ff  <= steps_in;
      found_ff  <= found_in;
      fr_ff     <= fr_in;
      rd_ff     <= rd_in;
      cell_ff   <= cell_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NIL_LINK)
      else $error("free-list head beyond nil");

   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      (ctl == DP_WALK || ctl == DP_FREE_WALK) |-> steps_ff <= CELL_COUNT)
      else $error("walk step count overran the store");

   a_fetch_clears: assert property (@(posedge clock) disable iff (reset)
      (ctl == DP_FETCH && req_valid) |=> (!found_ff && !fr_ff && status_ff == ST_OK))
      else $error("result state not cleared on a new transaction");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl == DP_EMIT))
      else $error("result raised outside the emit step");
`endif

endmodule

`default_nettype wire

// File: sv/linked_cell_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// Linked-cell free-list allocator core
// Top level: microsequencer, datapath and cell store.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time, and a result transaction is
// returned for each. Allocate checks the free-list head and, unless the list
// is empty, pops the head cell; write, read, count and is-free walk a chain
// from its first cell, a read or an is-free test stopping at a match, over
// at most all 64 cells; free follows the links to the chain's tail and
// splices the chain in front of the free list. The walk rate is set by the
// cell store's single registered read port, which delivers one link per
// cycle. A finished result waits in an output register, so the next request
// is taken while it is still pending. No clearing pass is needed after
// reset.
`default_nettype none

module linked_cell_free_list_allocator_core
   import lcfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lcfa_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lcfa_rsp_type rsp_data
);

   lcfa_dp_op_type    ctl;
   lcfa_flag_type     flags;
   lcfa_rdata_type    rdata;
   lcfa_wr_type       wr;
   logic [ADDR_W-1:0] rd_addr;

   lcfa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   lcfa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rdata     (rdata),
      .rd_addr   (rd_addr),
      .wr        (wr),
      .flags     (flags)
   );

   lcfa_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rdata   (rdata)
   );

endmodule

`default_nettype wire
